// File: rtl/core/lctg_pkg.sv
// shared types and constants of the linear chirp tone generator
`default_nettype none

package lctg_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_INC  = 3'd0,
    REG_INC_STEP   = 3'd1,
    REG_SAMPLE_CNT = 3'd2,
    REG_VOLUME     = 3'd3,
    REG_ENV_STEP   = 3'd4
  } reg_index_e;

  // per-word sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_OUT
  } seq_state_e;

  // register widths fixed by the port
  localparam int unsigned CfgWidth      = 31;
  localparam int unsigned IncStepWidth  = 21;
  localparam int unsigned CountRegWidth = 20;
  localparam int unsigned VolumeWidth   = 16;
  localparam int unsigned EnvWidth      = 17;
  localparam int unsigned TabWidth      = 15;

  localparam logic [EnvWidth-1:0]      EnvOne     = 17'h10000;
  localparam logic [VolumeWidth-1:0]   VolFull    = 16'h8000;
  localparam logic [EnvWidth-1:0]      MagMax     = 17'd32767;
  localparam logic [CountRegWidth-1:0] CountReset = 20'd1;

  // q30 coefficients of sin(pi/2 * u), signs folded into the horner form
  localparam logic [63:0] Coef1 = 64'd1686629713;
  localparam logic [63:0] Coef3 = 64'd693598668;
  localparam logic [63:0] Coef5 = 64'd85569306;
  localparam logic [63:0] Coef7 = 64'd5026995;
  localparam logic [63:0] Coef9 = 64'd172272;

endpackage

`default_nettype wire

// File: rtl/core/lctg_sine_rom.sv
// quarter-wave sine table with registered read
`default_nettype none

module lctg_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rd_en_i,
  input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0]   rd_addr_i,
  output logic      [lctg_pkg::TabWidth-1:0]         rd_data_o
);

  // entry k = round(32767 * sin(pi/2 * u)), u at the middle of bin k in q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] k);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    u  = ((64'd2 * k + 64'd1) << 29) / SINE_TABLE_DEPTH;
    u2 = (u * u) >> 30;
    t  = lctg_pkg::Coef9;
    t  = lctg_pkg::Coef7 - ((u2 * t) >> 30);
    t  = lctg_pkg::Coef5 - ((u2 * t) >> 30);
    t  = lctg_pkg::Coef3 - ((u2 * t) >> 30);
    t  = lctg_pkg::Coef1 - ((u2 * t) >> 30);
    t  = (u * t) >> 30;
    return (t * 64'd32767 + (64'd1 << 29)) >> 30;
  endfunction

  logic [lctg_pkg::TabWidth-1:0] tab_w [SINE_TABLE_DEPTH];

  // table contents settled at elaboration
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] Entry = quarter_sine(64'(k));
    assign tab_w[k] = Entry[lctg_pkg::TabWidth-1:0];
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= tab_w[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/linear_chirp_tone_generator.sv
// top level: dds chirp generator with note state held in a one-entry memory
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-----------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready  | tdata[0] restart
//  m_axis   | m_axis_tvalid/m_axis_tready  | tdata sample_value, tlast last
//           |                              | sample, tuser active
//  cfg      | cfg_we_i, no wait            | cfg_index_i register, cfg_data_i
//
// one input word goes through these steps: state memory read, update and write-back
// with table read, volume multiply, envelope multiply into the output register.
// the sequence runs one word at a time through the single state memory port.
// a stalled output holds the last step until the output register frees up;
// the next input word is taken while a finished word waits in that register.
// reset is asynchronous; the state memory reads as its reset values until
// its first write, so no clearing pass is needed.
`default_nettype none

module linear_chirp_tone_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned PHASE_WIDTH      = 32,
  parameter int unsigned COUNT_WIDTH      = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample_value
  output logic             m_axis_tlast,   // last_sample
  output logic             m_axis_tuser,   // [0] active
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i
);

  localparam int unsigned PW    = PHASE_WIDTH;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned QB    = PHASE_WIDTH - 2;
  localparam int unsigned IdxW  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DepW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned EW    = lctg_pkg::EnvWidth;
  localparam int unsigned TW    = lctg_pkg::TabWidth;
  localparam int unsigned VW    = lctg_pkg::VolumeWidth;
  localparam int unsigned P1W   = TW + VW;
  localparam int unsigned P2W   = P1W + EW;

  localparam logic [QB+DepW-1:0] DepthMul  = (QB+DepW)'(SINE_TABLE_DEPTH);
  localparam logic [IdxW-1:0]    DepthLast = IdxW'(SINE_TABLE_DEPTH - 1);

  typedef struct packed {
    logic          run;
    logic [CW-1:0] index;
    logic [EW-1:0] env;
    logic [PW-1:0] incr;
    logic [PW-1:0] phase;
  } note_state_t;

  localparam note_state_t StateReset = '{
    run: 1'b0, index: '0, env: lctg_pkg::EnvOne, incr: '0, phase: '0
  };

  // configuration registers
  logic [30:0]    start_inc_q;
  logic [20:0]    inc_step_q;
  logic [19:0]    sample_cnt_q;
  logic [VW-1:0]  volume_q;
  logic [EW-1:0]  env_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_inc_q  <= '0;
      inc_step_q   <= '0;
      sample_cnt_q <= lctg_pkg::CountReset;
      volume_q     <= lctg_pkg::VolFull;
      env_step_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lctg_pkg::REG_START_INC:  start_inc_q  <= cfg_data_i;
        lctg_pkg::REG_INC_STEP:   inc_step_q   <= cfg_data_i[20:0];
        lctg_pkg::REG_SAMPLE_CNT: sample_cnt_q <= cfg_data_i[19:0];
        lctg_pkg::REG_VOLUME:     volume_q     <= cfg_data_i[VW-1:0];
        lctg_pkg::REG_ENV_STEP:   env_step_q   <= cfg_data_i[EW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  lctg_pkg::seq_state_e state_q, state_d;
  logic                 out_free;
  logic                 in_fire;
  logic                 out_load;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lctg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      lctg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = lctg_pkg::ST_LOAD;
        end
      end
      lctg_pkg::ST_LOAD:  state_d = lctg_pkg::ST_SCALE;
      lctg_pkg::ST_SCALE: state_d = lctg_pkg::ST_OUT;
      lctg_pkg::ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = lctg_pkg::ST_IDLE;
        end
      end
      default: state_d = lctg_pkg::ST_IDLE;
    endcase
  end

  // note state memory, one entry, read on accept and written back in the next cycle
  note_state_t state_mem [1];
  note_state_t rd_data_q;
  logic        mem_valid_q;
  logic        rd_valid_q;
  logic        restart_q;
  logic        mem_we;
  note_state_t wr_data;

  assign mem_we = (state_q == lctg_pkg::ST_LOAD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[0] <= wr_data;
    end
    if (in_fire) begin
      rd_data_q <= state_mem[0];
      restart_q <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_valid_q <= 1'b1;
      end
      if (in_fire) begin
        rd_valid_q <= mem_valid_q;
      end
    end
  end

  // state update for this sample
  note_state_t            cur;
  logic [PW+30:0]         start_wide;
  logic [CW+19:0]         cnt_wide;
  logic [CW-1:0]          cnt;
  logic                   last;
  logic [PW-1:0]          step_ext;
  logic [QB+DepW-1:0]     idx_prod;
  logic [IdxW-1:0]        idx_raw;
  logic [IdxW-1:0]        tab_addr;
  logic [1:0]             quadrant;

  assign start_wide = {{PW{1'b0}}, start_inc_q};
  assign cnt_wide   = {{CW{1'b0}}, sample_cnt_q};
  assign step_ext   = {{(PW - 21){inc_step_q[20]}}, inc_step_q};

  always_comb begin
    cur = rd_valid_q ? rd_data_q : StateReset;
    if (restart_q) begin
      cur.phase = '0;
      cur.incr  = start_wide[PW-1:0];
      cur.env   = lctg_pkg::EnvOne;
      cur.index = '0;
      cur.run   = 1'b1;
    end

    cnt = cnt_wide[CW-1:0];
    if (cnt == '0) begin
      cnt = CW'(1);
    end
    last = (cur.index >= cnt - CW'(1));

    // table address from the phase, mirrored in odd quadrants
    quadrant = cur.phase[PW-1:PW-2];
    idx_prod = {{DepW{1'b0}}, cur.phase[QB-1:0]} * DepthMul;
    idx_raw  = idx_prod[QB +: IdxW];
    tab_addr = quadrant[0] ? (DepthLast - idx_raw) : idx_raw;

    wr_data = cur;
    if (cur.run) begin
      wr_data.phase = cur.phase + cur.incr;
      wr_data.incr  = cur.incr + step_ext;
      wr_data.env   = (cur.env > env_step_q) ? (cur.env - env_step_q) : '0;
      wr_data.index = cur.index + CW'(1);
      wr_data.run   = !last;
    end
  end

  logic [TW-1:0] tab_data;

  lctg_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (mem_we),
    .rd_addr_i (tab_addr),
    .rd_data_o (tab_data)
  );

  // sample attributes carried along the multiply steps
  logic          neg_q;
  logic          last_q;
  logic          active_q;
  logic [EW-1:0] env_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      neg_q    <= quadrant[1];
      last_q   <= cur.run && last;
      active_q <= cur.run;
      env_q    <= cur.env;
    end
  end

  // volume multiply
  logic [VW-1:0]  vol_eff;
  logic [P1W-1:0] prod1_q;

  assign vol_eff = (volume_q > lctg_pkg::VolFull) ? lctg_pkg::VolFull : volume_q;

  always_ff @(posedge clk_i) begin
    if (state_q == lctg_pkg::ST_SCALE) begin
      prod1_q <= P1W'(tab_data) * P1W'(vol_eff);
    end
  end

  // envelope multiply, clamp and sign
  logic [P2W-1:0] prod2;
  logic [EW-1:0]  mag;
  logic [15:0]    sample;

  always_comb begin
    prod2 = P2W'(prod1_q) * P2W'(env_q);
    mag   = prod2[31 +: EW];
    if (mag > lctg_pkg::MagMax) begin
      mag = lctg_pkg::MagMax;
    end
    sample = neg_q ? (16'd0 - mag[15:0]) : mag[15:0];
    if (!active_q) begin
      sample = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= sample;
      m_axis_tlast <= last_q;
      m_axis_tuser <= active_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lctg_checker.sv
// port-level checks of the chirp generator and their binding
`default_nettype none

module lctg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // a silent word carries zero and no end mark
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0 && !m_axis_tlast)
    else $error("silent word with nonzero sample or end mark");

  // clamp keeps samples inside +-32767
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 16'h8000)
    else $error("sample outside clamp range");

  // an input word is never taken in the cycle right after another
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input words taken back to back");

  // stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind linear_chirp_tone_generator lctg_checker u_lctg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
